// File: src/rict_pkg.sv
package rict_pkg;

    // Operation codes carried in the operation field
    localparam logic [2:0] OP_GET        = 3'd0;
    localparam logic [2:0] OP_DUP        = 3'd1;
    localparam logic [2:0] OP_PUT        = 3'd2;
    localparam logic [2:0] OP_LOCK       = 3'd3;
    localparam logic [2:0] OP_UNLOCK     = 3'd4;
    localparam logic [2:0] OP_UNLOCK_PUT = 3'd5;

    // Status codes returned with every result
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_BUSY   = 2'd2;
    localparam logic [1:0] ST_MISUSE = 2'd3;

    // Fixed field widths of the stream payloads
    localparam int OP_W       = 3;
    localparam int INO_FIELD_W = 16;
    localparam int IDX_FIELD_W = 8;
    localparam int REF_FIELD_W = 16;
    localparam int TDATA_W    = 32;

    typedef logic [2:0] op_t;
    typedef logic [1:0] status_t;

    // Outcome of one operation, passed from the execute unit to the control
    typedef struct packed {
        status_t status;
        logic    hit;
        logic    needs_load;
        logic    free_inode;
        logic    addressed;
        logic    claim;
    } exec_flags_t;

endpackage

// File: src/rict_ram.sv
module rict_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: src/rict_exec.sv
module rict_exec #(
    parameter int REF_BITS = 16
) (
    input  rict_pkg::op_t               op,
    input  logic                        found,
    input  logic                        have_empty,
    input  logic                        in_range,
    input  logic                        links_zero,
    input  logic [REF_BITS-1:0]         refs_in,
    input  logic                        busy_in,
    input  logic                        valid_in,
    output logic [REF_BITS-1:0]         refs_out,
    output logic                        busy_out,
    output logic                        valid_out,
    output logic [rict_pkg::REF_FIELD_W-1:0] ref_after,
    output rict_pkg::exec_flags_t       flags
);

    import rict_pkg::*;

    localparam logic [REF_BITS-1:0] REF_MAX = '1;
    localparam logic [REF_BITS-1:0] REF_ONE = REF_BITS'(1);

    logic                           refs_zero;
    logic                           refs_full;
    logic                           last_ref;
    logic [REF_BITS+REF_FIELD_W-1:0] refs_wide;

    assign refs_zero = (refs_in == '0);
    assign refs_full = (refs_in == REF_MAX);
    assign last_ref  = (refs_in == REF_ONE) && valid_in && links_zero;

    // Decide the new slot state and the outcome of the operation
    always_comb
    begin
        refs_out  = refs_in;
        busy_out  = busy_in;
        valid_out = valid_in;
        flags     = '0;
        flags.status = ST_OK;
        if (op == OP_GET)
        begin
            if (found)
            begin
                flags.hit       = 1'b1;
                flags.addressed = 1'b1;
                if (refs_full)
                begin
                    flags.status = ST_MISUSE;
                end
                else
                begin
                    refs_out = refs_in + REF_ONE;
                end
            end
            else if (have_empty)
            begin
                flags.addressed = 1'b1;
                flags.claim     = 1'b1;
                refs_out  = REF_ONE;
                busy_out  = 1'b0;
                valid_out = 1'b0;
            end
            else
            begin
                flags.status = ST_FULL;
            end
        end
        else if (!in_range || (op > OP_UNLOCK_PUT))
        begin
            flags.status    = ST_MISUSE;
            flags.addressed = in_range;
        end
        else
        begin
            flags.addressed = 1'b1;
            unique case (op)
                OP_DUP:
                begin
                    if (refs_zero || refs_full)
                    begin
                        flags.status = ST_MISUSE;
                    end
                    else
                    begin
                        refs_out = refs_in + REF_ONE;
                    end
                end
                OP_PUT:
                begin
                    if (refs_zero || (last_ref && busy_in))
                    begin
                        flags.status = ST_MISUSE;
                    end
                    else
                    begin
                        if (last_ref)
                        begin
                            busy_out         = 1'b1;
                            flags.free_inode = 1'b1;
                        end
                        refs_out = refs_in - REF_ONE;
                    end
                end
                OP_LOCK:
                begin
                    if (refs_zero)
                    begin
                        flags.status = ST_MISUSE;
                    end
                    else if (busy_in)
                    begin
                        flags.status = ST_BUSY;
                    end
                    else
                    begin
                        busy_out = 1'b1;
                        if (!valid_in)
                        begin
                            flags.needs_load = 1'b1;
                            valid_out        = 1'b1;
                        end
                    end
                end
                OP_UNLOCK:
                begin
                    if (refs_zero || !busy_in)
                    begin
                        flags.status = ST_MISUSE;
                    end
                    else
                    begin
                        busy_out = 1'b0;
                    end
                end
                OP_UNLOCK_PUT:
                begin
                    // Unlock clears busy, so the put that follows cannot be refused
                    if (refs_zero || !busy_in)
                    begin
                        flags.status = ST_MISUSE;
                    end
                    else
                    begin
                        busy_out = 1'b0;
                        if (last_ref)
                        begin
                            busy_out         = 1'b1;
                            flags.free_inode = 1'b1;
                        end
                        refs_out = refs_in - REF_ONE;
                    end
                end
                default:
                begin
                    flags.status = ST_MISUSE;
                end
            endcase
        end
    end

    // Report the count after the operation, low bits only
    assign refs_wide = {{REF_FIELD_W{1'b0}}, refs_out};
    assign ref_after = flags.addressed ? refs_wide[REF_FIELD_W-1:0] : '0;

endmodule

// File: src/refcounted_inode_cache_table.sv
// Reference-counted inode cache table.
// Input channel s_*: one transaction carries an operation (get, dup, put,
// lock, unlock, unlock then put) with an inode number, a slot index and a
// link flag. Output channel m_*: exactly one result transaction per input,
// in order, carrying the slot, a status code and the count after the step.
// Slot state (count, busy, valid) lives in one synchronous RAM and the
// cached inode numbers in a second; each operation is a read, a modify in
// the execute unit and a write back. Only one operation is in flight.
// A get scans the slots in order one per cycle, stopping early when the
// inode is found; every other operation reads the addressed slot only.
// Both then execute and write back, loading the result register.
// After reset the block runs a clearing pass over every entry of the
// slot state RAM with s_tready low; the inode RAM is not cleared.
// The result sits in an output register: s_tready returns as soon as the
// write back is done, even if the result has not been taken. If m_tready
// is held low the next operation waits before its write back until the
// output register is free.
module refcounted_inode_cache_table #(
    parameter int CACHE_ENTRIES = 256,
    parameter int INODE_BITS    = 16,
    parameter int REF_BITS      = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // operation[2:0], inode_number[18:3], slot_index[26:19], links_zero[27]
    input  logic [rict_pkg::TDATA_W-1:0] s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // result_slot[7:0], status[9:8], hit[10], needs_load[11],
    // free_inode[12], ref_after[28:13]
    output logic [rict_pkg::TDATA_W-1:0] m_tdata
);

    import rict_pkg::*;

    localparam int IDX_W  = $clog2(CACHE_ENTRIES);
    localparam int CNT_W  = IDX_W + 1;
    localparam int META_W = REF_BITS + 2;
    localparam logic [CNT_W-1:0] SCAN_END = CNT_W'(CACHE_ENTRIES);
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(CACHE_ENTRIES - 1);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_EXEC  = 3'd4;

    // Input fields
    op_t                    in_op;
    logic [INO_FIELD_W-1:0] in_ino;
    logic [IDX_FIELD_W-1:0] in_idx;
    logic                   in_lz;
    logic [INODE_BITS+INO_FIELD_W-1:0] ino_wide;
    logic [IDX_W+IDX_FIELD_W-1:0]      idx_wide;

    // Control
    logic [2:0]       state_reg, state_next;
    logic [IDX_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic [CNT_W-1:0] scan_cnt_reg, scan_cnt_next;
    logic             rd_pend_reg, rd_pend_next;
    logic             found_reg, found_next;
    logic             have_empty_reg, have_empty_next;
    logic             out_valid_reg, out_valid_next;

    // Payload
    op_t                    op_reg;
    logic [INODE_BITS-1:0]  ino_reg;
    logic [IDX_FIELD_W-1:0] idx_reg;
    logic                   lz_reg;
    logic                   in_range_reg;
    logic [IDX_W-1:0]       rd_slot_reg, rd_slot_next;
    logic [IDX_W-1:0]       hit_slot_reg, hit_slot_next;
    logic [IDX_W-1:0]       empty_slot_reg, empty_slot_next;
    logic [TDATA_W-1:0]     out_data_reg;

    // Memory ports
    logic              meta_we, ino_we, mem_re;
    logic [IDX_W-1:0]  meta_waddr, mem_raddr, target_slot;
    logic [META_W-1:0] meta_wdata, meta_rdata;
    logic [INODE_BITS-1:0] ino_rdata;

    // Execute unit
    logic [REF_BITS-1:0]    refs_new;
    logic                   busy_new, valid_new;
    logic [REF_FIELD_W-1:0] ref_after;
    exec_flags_t            flags;

    logic accept, scan_issue, scan_match, exec_go;
    logic [IDX_W+IDX_FIELD_W-1:0] slot_wide;
    logic [IDX_FIELD_W-1:0]       result_slot;

    assign in_op  = s_tdata[OP_W-1:0];
    assign in_ino = s_tdata[OP_W+INO_FIELD_W-1:OP_W];
    assign in_idx = s_tdata[OP_W+INO_FIELD_W+IDX_FIELD_W-1:OP_W+INO_FIELD_W];
    assign in_lz  = s_tdata[OP_W+INO_FIELD_W+IDX_FIELD_W];
    assign ino_wide = {{INODE_BITS{1'b0}}, in_ino};
    assign idx_wide = {{IDX_W{1'b0}}, idx_reg};

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Scan compare on the entry read in the previous cycle
    assign scan_issue = (scan_cnt_reg != SCAN_END);
    assign scan_match = rd_pend_reg && (meta_rdata[REF_BITS-1:0] != '0)
                        && (ino_rdata == ino_reg);
    assign exec_go    = (state_reg == S_EXEC) && (!out_valid_reg || m_tready);

    // Slot operated on in the execute cycle
    always_comb
    begin
        if (op_reg == OP_GET)
        begin
            target_slot = found_reg ? hit_slot_reg : empty_slot_reg;
        end
        else
        begin
            target_slot = idx_wide[IDX_W-1:0];
        end
    end

    // Read port: scan address or the addressed slot
    always_comb
    begin
        mem_raddr = (state_reg == S_SCAN) ? scan_cnt_reg[IDX_W-1:0] : idx_wide[IDX_W-1:0];
        mem_re    = ((state_reg == S_SCAN) && scan_issue && !scan_match)
                    || (state_reg == S_READ);
    end

    // Write port: clearing pass or write back
    always_comb
    begin
        if (state_reg == S_CLEAR)
        begin
            meta_we    = 1'b1;
            meta_waddr = clr_cnt_reg;
            meta_wdata = '0;
        end
        else
        begin
            meta_we    = exec_go && (flags.status == ST_OK);
            meta_waddr = target_slot;
            meta_wdata = {valid_new, busy_new, refs_new};
        end
        ino_we = exec_go && flags.claim;
    end

    rict_ram #(
        .WIDTH (META_W),
        .DEPTH (CACHE_ENTRIES)
    ) u_meta_ram (
        .clk   (clk),
        .we    (meta_we),
        .waddr (meta_waddr),
        .wdata (meta_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (meta_rdata)
    );

    rict_ram #(
        .WIDTH (INODE_BITS),
        .DEPTH (CACHE_ENTRIES)
    ) u_inode_ram (
        .clk   (clk),
        .we    (ino_we),
        .waddr (target_slot),
        .wdata (ino_reg),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (ino_rdata)
    );

    rict_exec #(
        .REF_BITS (REF_BITS)
    ) u_exec (
        .op         (op_reg),
        .found      (found_reg),
        .have_empty (have_empty_reg),
        .in_range   (in_range_reg),
        .links_zero (lz_reg),
        .refs_in    (meta_rdata[REF_BITS-1:0]),
        .busy_in    (meta_rdata[REF_BITS]),
        .valid_in   (meta_rdata[REF_BITS+1]),
        .refs_out   (refs_new),
        .busy_out   (busy_new),
        .valid_out  (valid_new),
        .ref_after  (ref_after),
        .flags      (flags)
    );

    // Result slot: get reports the found or claimed slot, 0 when full
    assign slot_wide = {{IDX_FIELD_W{1'b0}}, target_slot};
    always_comb
    begin
        if (op_reg != OP_GET)
        begin
            result_slot = idx_reg;
        end
        else if (flags.addressed)
        begin
            result_slot = slot_wide[IDX_FIELD_W-1:0];
        end
        else
        begin
            result_slot = '0;
        end
    end

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        scan_cnt_next   = scan_cnt_reg;
        rd_pend_next    = rd_pend_reg;
        found_next      = found_reg;
        have_empty_next = have_empty_reg;
        rd_slot_next    = rd_slot_reg;
        hit_slot_next   = hit_slot_reg;
        empty_slot_next = empty_slot_reg;
        out_valid_next  = out_valid_reg;
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + IDX_W'(1);
                if (clr_cnt_reg == LAST_SLOT)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    scan_cnt_next   = '0;
                    rd_pend_next    = 1'b0;
                    found_next      = 1'b0;
                    have_empty_next = 1'b0;
                    state_next      = (in_op == OP_GET) ? S_SCAN : S_READ;
                end
            end
            S_SCAN:
            begin
                // Note the first free slot seen before any hit
                if (rd_pend_reg && !have_empty_reg && (meta_rdata[REF_BITS-1:0] == '0))
                begin
                    have_empty_next = 1'b1;
                    empty_slot_next = rd_slot_reg;
                end
                rd_pend_next = scan_issue;
                rd_slot_next = scan_cnt_reg[IDX_W-1:0];
                if (scan_issue)
                begin
                    scan_cnt_next = scan_cnt_reg + CNT_W'(1);
                end
                if (scan_match)
                begin
                    found_next    = 1'b1;
                    hit_slot_next = rd_slot_reg;
                    state_next    = S_EXEC;
                end
                else if (!scan_issue)
                begin
                    state_next = S_EXEC;
                end
            end
            S_READ:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (exec_go)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_cnt_reg    <= '0;
            scan_cnt_reg   <= '0;
            rd_pend_reg    <= 1'b0;
            found_reg      <= 1'b0;
            have_empty_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            scan_cnt_reg   <= scan_cnt_next;
            rd_pend_reg    <= rd_pend_next;
            found_reg      <= found_next;
            have_empty_reg <= have_empty_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Hold the transaction fields and scan results
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg       <= in_op;
            ino_reg      <= ino_wide[INODE_BITS-1:0];
            idx_reg      <= in_idx;
            lz_reg       <= in_lz;
            in_range_reg <= ({{(32-IDX_FIELD_W){1'b0}}, in_idx} < 32'(CACHE_ENTRIES));
        end
        rd_slot_reg    <= rd_slot_next;
        hit_slot_reg   <= hit_slot_next;
        empty_slot_reg <= empty_slot_next;
        if (exec_go)
        begin
            out_data_reg <= {3'b000, ref_after, flags.free_inode, flags.needs_load,
                             flags.hit, flags.status, result_slot};
        end
    end

endmodule

// File: tb/tb_refcounted_inode_cache_table.sv
`timescale 1ns / 1ps

module tb_refcounted_inode_cache_table;
    import rict_pkg::*;

    localparam int          SLOTS        = 256;
    localparam logic [15:0] REF_LIMIT    = 16'hFFFF;
    localparam op_t         OP_RSVD_6    = 3'd6;
    localparam op_t         OP_RSVD_7    = 3'd7;
    localparam int          CYCLE_LIMIT  = 4000000;
    localparam int          DRAIN_CYCLES = SLOTS + 40;
    localparam int          MAX_REPORTS  = 40;

    // One expected result transaction
    typedef struct packed {
        logic [7:0]  slot;
        status_t     status;
        logic        hit;
        logic        needs_load;
        logic        free_inode;
        logic [15:0] refs;
    } cache_result_t;

    logic               clk;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata;
    logic               m_tvalid;
    logic               m_tready;
    logic [TDATA_W-1:0] m_tdata;

    // Shadow copy of the slot table
    logic [15:0] shadow_ino  [SLOTS];
    logic [15:0] shadow_refs [SLOTS];
    bit          shadow_busy [SLOTS];
    bit          shadow_valid[SLOTS];

    cache_result_t pending_results[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int errors         = 0;
    int cycle_count    = 0;
    int ops_sent       = 0;
    int results_seen   = 0;
    int n_hits         = 0;
    int n_loads        = 0;
    int n_frees        = 0;
    int n_full         = 0;
    int n_refused      = 0;
    int n_misuse       = 0;

    refcounted_inode_cache_table dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Drop a reference; the last one on a loaded, unlinked inode frees it unless locked (misuse)
    function automatic status_t drop_ref(input int s, input logic unlinked, output logic freed);
        freed = 1'b0;
        if (shadow_refs[s] == 16'd0)
            return ST_MISUSE;
        if (shadow_refs[s] == 16'd1 && shadow_valid[s] && unlinked)
        begin
            if (shadow_busy[s])
                return ST_MISUSE;
            shadow_busy[s] = 1'b1;
            freed = 1'b1;
        end
        shadow_refs[s] = shadow_refs[s] - 16'd1;
        return ST_OK;
    endfunction

    function automatic status_t release_lock(input int s);
        if (shadow_refs[s] == 16'd0 || !shadow_busy[s])
            return ST_MISUSE;
        shadow_busy[s] = 1'b0;
        return ST_OK;
    endfunction

    // Apply one operation to the shadow table and return its result
    function automatic cache_result_t cache_outcome(input op_t op, input logic [15:0] ino,
                                                    input logic [7:0] idx, input logic unlinked);
        cache_result_t r;
        int hit_at;
        int free_at;
        int s;
        int i;
        logic freed;
        r = '0;
        s = idx;
        freed = 1'b0;
        r.status = ST_OK;
        if (op == OP_GET)
        begin
            hit_at = -1;
            free_at = -1;
            for (i = 0; i < SLOTS; i++)
            begin
                if (hit_at < 0 && shadow_refs[i] != 16'd0 && shadow_ino[i] == ino)
                    hit_at = i;
                if (free_at < 0 && shadow_refs[i] == 16'd0)
                    free_at = i;
            end
            if (hit_at >= 0)
            begin
                s = hit_at;
                r.hit = 1'b1;
                if (shadow_refs[s] == REF_LIMIT)
                    r.status = ST_MISUSE;
                else
                    shadow_refs[s] = shadow_refs[s] + 16'd1;
            end
            else if (free_at >= 0)
            begin
                s = free_at;
                shadow_ino[s]   = ino;
                shadow_refs[s]  = 16'd1;
                shadow_busy[s]  = 1'b0;
                shadow_valid[s] = 1'b0;
            end
            else
            begin
                s = -1;
                r.status = ST_FULL;
            end
        end
        else
        begin
            case (op)
                OP_DUP:
                begin
                    if (shadow_refs[s] == 16'd0 || shadow_refs[s] == REF_LIMIT)
                        r.status = ST_MISUSE;
                    else
                        shadow_refs[s] = shadow_refs[s] + 16'd1;
                end
                OP_PUT:
                    r.status = drop_ref(s, unlinked, freed);
                OP_LOCK:
                begin
                    if (shadow_refs[s] == 16'd0)
                        r.status = ST_MISUSE;
                    else if (shadow_busy[s])
                        r.status = ST_BUSY;
                    else
                    begin
                        shadow_busy[s] = 1'b1;
                        if (!shadow_valid[s])
                        begin
                            r.needs_load = 1'b1;
                            shadow_valid[s] = 1'b1;
                        end
                    end
                end
                OP_UNLOCK:
                    r.status = release_lock(s);
                OP_UNLOCK_PUT:
                begin
                    r.status = release_lock(s);
                    if (r.status == ST_OK)
                        r.status = drop_ref(s, unlinked, freed);
                end
                default:
                    r.status = ST_MISUSE;
            endcase
        end
        r.free_inode = freed;
        r.slot = (s < 0) ? 8'd0 : s[7:0];
        r.refs = (s < 0) ? 16'd0 : shadow_refs[s];
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        if (errors < MAX_REPORTS)
            $display("[%0t] mismatch on %s: got %h, expected %h (result %0d)",
                     $time, field, got, want, results_seen);
        errors++;
    endtask

    // Send one operation: idle at random, then hold the transaction until taken
    task automatic send_op(input op_t op, input logic [15:0] ino, input logic [7:0] idx,
                           input logic unlinked);
        cache_result_t want;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, unlinked, idx, ino, op};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        want = cache_outcome(op, ino, idx, unlinked);
        pending_results.push_back(want);
        ops_sent++;
        if (want.hit)
            n_hits++;
        if (want.needs_load)
            n_loads++;
        if (want.free_inode)
            n_frees++;
        case (want.status)
            ST_FULL:   n_full++;
            ST_BUSY:   n_refused++;
            ST_MISUSE: n_misuse++;
            default:   ;
        endcase
    endtask

    task automatic check_result(input logic [TDATA_W-1:0] word);
        cache_result_t want;
        if (pending_results.size() == 0)
        begin
            report_mismatch("result with nothing outstanding", word, 32'd0);
            return;
        end
        want = pending_results.pop_front();
        results_seen++;
        if (word[7:0] !== want.slot)
            report_mismatch("result_slot", word[7:0], want.slot);
        if (word[9:8] !== want.status)
            report_mismatch("status", word[9:8], want.status);
        if (word[10] !== want.hit)
            report_mismatch("hit", word[10], want.hit);
        if (word[11] !== want.needs_load)
            report_mismatch("needs_load", word[11], want.needs_load);
        if (word[12] !== want.free_inode)
            report_mismatch("free_inode", word[12], want.free_inode);
        if (word[28:13] !== want.refs)
            report_mismatch("ref_after", word[28:13], want.refs);
        if (word[31:29] !== 3'b000)
            report_mismatch("padding", word[31:29], 3'b000);
    endtask

    // Stall the result channel at random
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    // Check every result transaction against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            check_result(m_tdata);
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_refcounted_inode_cache_table: timeout after %0d cycles", cycle_count);
            $display("tb_refcounted_inode_cache_table: errors");
            $finish;
        end
    end

    // Lifecycle of single slots, field extremes, misuse cases (none at the count limit) and undefined codes
    task automatic test_directed();
        send_op(OP_GET,        16'h0000, 8'd0,   1'b0);
        send_op(OP_GET,        16'hFFFF, 8'd255, 1'b1);
        send_op(OP_GET,        16'h0000, 8'd0,   1'b0);
        send_op(OP_DUP,        16'hFFFF, 8'd1,   1'b1);
        send_op(OP_PUT,        16'h0000, 8'd1,   1'b0);
        send_op(OP_LOCK,       16'h0000, 8'd1,   1'b0);
        send_op(OP_LOCK,       16'h0000, 8'd1,   1'b0);
        send_op(OP_UNLOCK,     16'h0000, 8'd1,   1'b0);
        send_op(OP_UNLOCK,     16'h0000, 8'd1,   1'b0);
        send_op(OP_PUT,        16'h0000, 8'd1,   1'b1);
        // slot 1 is now unreferenced: everything but get is misuse
        send_op(OP_DUP,        16'h0000, 8'd1,   1'b0);
        send_op(OP_PUT,        16'h0000, 8'd1,   1'b1);
        send_op(OP_LOCK,       16'h0000, 8'd1,   1'b0);
        send_op(OP_UNLOCK,     16'h0000, 8'd1,   1'b0);
        send_op(OP_UNLOCK_PUT, 16'h0000, 8'd1,   1'b1);
        // reclaim, then a last put on a locked unlinked inode
        send_op(OP_GET,        16'h5AA5, 8'd0,   1'b0);
        send_op(OP_LOCK,       16'h0000, 8'd1,   1'b0);
        send_op(OP_PUT,        16'h0000, 8'd1,   1'b1);
        send_op(OP_UNLOCK_PUT, 16'h0000, 8'd1,   1'b1);
        send_op(OP_RSVD_6,     16'hFFFF, 8'd0,   1'b1);
        send_op(OP_RSVD_7,     16'h0000, 8'd255, 1'b0);
        send_op(OP_DUP,        16'h0000, 8'd255, 1'b0);
        send_op(OP_PUT,        16'h0000, 8'd0,   1'b1);
        send_op(OP_LOCK,       16'h0000, 8'd0,   1'b0);
        send_op(OP_UNLOCK,     16'h0000, 8'd0,   1'b0);
        send_op(OP_PUT,        16'h0000, 8'd0,   1'b0);
    endtask

    function automatic bit table_has_room();
        int i;
        for (i = 0; i < SLOTS; i++)
        begin
            if (shadow_refs[i] == 16'd0)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    // Fill every slot, miss and hit on a full table, then release all
    task automatic test_table_full();
        int n;
        int s;
        n = 0;
        while (table_has_room())
        begin
            send_op(OP_GET, 16'h8000 + n[15:0], 8'($urandom_range(255)), 1'($urandom_range(1)));
            n++;
        end
        send_op(OP_GET, 16'h7FFF, 8'd0, 1'b0);
        send_op(OP_GET, 16'h8011, 8'd255, 1'b1);
        for (s = 0; s < SLOTS; s++)
        begin
            while (shadow_refs[s] != 16'd0)
                send_op(OP_PUT, 16'($urandom_range(16'hFFFF)), s[7:0], 1'($urandom_range(1)));
        end
    endtask

    // Mostly operations on live slots over a small inode pool, some noise
    task automatic test_random(input int count, input int idle_pct, input int stall_pct);
        int live[$];
        int i;
        int pick;
        op_t op;
        logic [15:0] ino;
        logic [7:0] idx;
        logic unlinked;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count)
        begin
            live.delete();
            for (i = 0; i < SLOTS; i++)
            begin
                if (shadow_refs[i] != 16'd0)
                    live.push_back(i);
            end
            pick     = $urandom_range(99);
            unlinked = 1'($urandom_range(1));
            ino      = 16'($urandom_range(16'hFFFF));
            idx      = 8'($urandom_range(255));
            if (pick < 30 || live.size() == 0)
            begin
                op = OP_GET;
                if ($urandom_range(3) != 0)
                    ino = 16'h0100 + 16'($urandom_range(23));
            end
            else if (pick < 88)
            begin
                idx = 8'(live[$urandom_range(live.size() - 1)]);
                case ($urandom_range(5))
                    0:       op = OP_DUP;
                    1, 2:    op = OP_PUT;
                    3:       op = OP_LOCK;
                    4:       op = OP_UNLOCK;
                    default: op = OP_UNLOCK_PUT;
                endcase
            end
            else
                op = 3'($urandom_range(7));
            send_op(op, ino, idx, unlinked);
        end
    endtask

    initial
    begin
        int i;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b0;
        for (i = 0; i < SLOTS; i++)
        begin
            shadow_ino[i]   = 16'd0;
            shadow_refs[i]  = 16'd0;
            shadow_busy[i]  = 1'b0;
            shadow_valid[i] = 1'b0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_table_full();
        test_random(125, 0, 0);
        test_random(125, 74, 0);
        test_random(125, 0, 74);
        test_random(125, 15, 15);

        // Drain outstanding results, then watch for strays
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d operations: %0d hits, %0d loads, %0d frees, %0d full, %0d refused",
                 ops_sent, n_hits, n_loads, n_frees, n_full, n_refused);
        $display("%0d misuse cases, %0d results compared, %0d mismatches",
                 n_misuse, results_seen, errors);
        if (errors == 0)
            $display("tb_refcounted_inode_cache_table: clean");
        else
            $display("tb_refcounted_inode_cache_table: errors");
        $finish;
    end

endmodule
